/* rtl/ssfq_pkg.sv */
// ----------------------------------------------------------------------------
// ssfq_pkg
// Shared types and constants for the strip sensor frame qualifier.
// ----------------------------------------------------------------------------
package ssfq_pkg;

  localparam logic [7:0]  HDR_BYTE   = 8'hAA;
  localparam int unsigned SECOND_BIT = 12;
  localparam logic [11:0] NO_STRIP   = 12'h7FF;

  // configuration register indexes
  localparam logic [1:0] CFG_PRESENT_RUN = 2'd0;
  localparam logic [1:0] CFG_ABSENT_RUN  = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

  typedef struct packed {
    logic [3:0] present_run_needed;
    logic [3:0] absent_run_needed;
    logic [3:0] frame_timeout_ticks;
  } ssfq_cfg_t;

  // input item as held in the input register
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       test_pin;
    logic       clear_present;
  } ssfq_item_t;

  // completed frame seen by the parser in the current tick
  typedef struct packed {
    logic        good;
    logic        bad;
    logic [15:0] word;
  } ssfq_frame_t;

endpackage

/* rtl/strip_sensor_frame_qualifier.sv */
// ----------------------------------------------------------------------------
// strip_sensor_frame_qualifier
// Parses 4-byte strip sensor frames, one tick per transaction, and qualifies
// the strip present flag over runs of frames.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction is one tick: an optional received byte plus the
//   test pin and consumer clear. Each tick gives exactly one result
//   transaction with the present flag, last good reading and frame status.
//   The input is captured in an input register, the tick is evaluated in one
//   pass of logic and written to the result register, which drives
//   out_valid_o; a held result can stall the tick between the two
//   registers. The block takes one tick per cycle while out_stall_i is
//   low.
//   The result register is the state itself, so when out_stall_i is high the
//   held result stays put; the input register still takes one more tick, and
//   in_stall_o rises only when both stages are full.
//   Configuration writes (index 0 present run, 1 absent run, 2 frame
//   timeout) are taken in any cycle; cfg_ready_o is always high. Write them
//   only while no tick is in flight.
//   Reset clears the parser, run counters, flags and held reading to zero
//   and all three thresholds to 3.
// ----------------------------------------------------------------------------
module strip_sensor_frame_qualifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        byte_valid_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        test_pin_i,
  input  logic        clear_present_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        strip_present_o,
  output logic        second_strip_o,
  output logic [11:0] strip_reading_o,
  output logic        frame_good_o,
  output logic        frame_bad_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);
  import ssfq_pkg::*;

  ssfq_cfg_t   cfg_q;
  ssfq_item_t  item_q;
  ssfq_frame_t frame;
  logic        item_valid_q;
  logic        out_valid_q;
  logic        good_q, bad_q;
  logic        out_free;
  logic        advance;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.present_run_needed  <= 4'd3;
      cfg_q.absent_run_needed   <= 4'd3;
      cfg_q.frame_timeout_ticks <= 4'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PRESENT_RUN: cfg_q.present_run_needed  <= cfg_data_i;
        CFG_ABSENT_RUN:  cfg_q.absent_run_needed   <= cfg_data_i;
        CFG_TIMEOUT:     cfg_q.frame_timeout_ticks <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.byte_valid    <= byte_valid_i;
      item_q.rx_byte       <= rx_byte_i;
      item_q.test_pin      <= test_pin_i;
      item_q.clear_present <= clear_present_i;
    end
  end

  ssfq_parser u_parser (
    .clk_i,
    .rst_ni,
    .advance_i       (advance),
    .item_i          (item_q),
    .timeout_ticks_i (cfg_q.frame_timeout_ticks),
    .frame_o         (frame)
  );

  ssfq_qualifier u_qualifier (
    .clk_i,
    .rst_ni,
    .advance_i (advance),
    .item_i    (item_q),
    .frame_i   (frame),
    .cfg_i     (cfg_q),
    .present_o (strip_present_o),
    .second_o  (second_strip_o),
    .reading_o (strip_reading_o)
  );

  // result register status bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      good_q      <= 1'b0;
      bad_q       <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= item_valid_q;
      if (advance) begin
        good_q <= frame.good;
        bad_q  <= frame.bad;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_good_o = good_q;
  assign frame_bad_o  = bad_q;

  a_good_bad_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(frame_good_o && frame_bad_o))
    else $error("frame reported both good and bad");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && item_valid_q))
    else $error("input stalled with room in the pipeline");

  a_clear_wins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.clear_present) |=> (out_valid_o && !strip_present_o))
    else $error("present flag not cleared by consumer");

  a_result_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("evaluated tick produced no result");

endmodule

/* rtl/ssfq_parser.sv */
// ----------------------------------------------------------------------------
// ssfq_parser
// Byte-level frame parser: header hunt, data capture, checksum and timeout.
// ----------------------------------------------------------------------------
module ssfq_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  ssfq_pkg::ssfq_item_t item_i,
  input  logic [3:0]           timeout_ticks_i,
  output ssfq_pkg::ssfq_frame_t frame_o
);
  import ssfq_pkg::*;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_HIGH,
    ST_LOW,
    ST_CHECK
  } step_e;

  step_e       step_q, step_d;
  logic [3:0]  timeout_q, timeout_d;
  logic [15:0] word_q, word_d;
  logic [7:0]  sum;

  assign sum = HDR_BYTE + word_q[15:8] + word_q[7:0];

  always_comb begin
    step_d        = step_q;
    timeout_d     = timeout_q;
    word_d        = word_q;
    frame_o.good  = 1'b0;
    frame_o.bad   = 1'b0;
    frame_o.word  = word_q;
    if (item_i.byte_valid) begin
      unique case (step_q)
        ST_HEADER: begin
          if (item_i.rx_byte == HDR_BYTE) begin
            step_d    = ST_HIGH;
            timeout_d = timeout_ticks_i;
          end
        end
        ST_HIGH: begin
          word_d = {8'h00, item_i.rx_byte};
          step_d = ST_LOW;
        end
        ST_LOW: begin
          word_d = {word_q[7:0], item_i.rx_byte};
          step_d = ST_CHECK;
        end
        ST_CHECK: begin
          frame_o.good = (item_i.rx_byte == sum);
          frame_o.bad  = (item_i.rx_byte != sum);
          step_d       = ST_HEADER;
          timeout_d    = 4'd0;
        end
        default: step_d = ST_HEADER;
      endcase
    end else if (timeout_q != 4'd0) begin
      timeout_d = timeout_q - 4'd1;
      // partial frame dropped when the count runs out
      if (timeout_q == 4'd1) begin
        step_d = ST_HEADER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= ST_HEADER;
      timeout_q <= 4'd0;
      word_q    <= 16'h0000;
    end else if (advance_i) begin
      step_q    <= step_d;
      timeout_q <= timeout_d;
      word_q    <= word_d;
    end
  end

endmodule

/* rtl/ssfq_qualifier.sv */
// ----------------------------------------------------------------------------
// ssfq_qualifier
// Run counters and present flag; holds the reading of the last good frame.
// ----------------------------------------------------------------------------
module ssfq_qualifier (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  ssfq_pkg::ssfq_item_t  item_i,
  input  ssfq_pkg::ssfq_frame_t frame_i,
  input  ssfq_pkg::ssfq_cfg_t   cfg_i,
  output logic                  present_o,
  output logic                  second_o,
  output logic [11:0]           reading_o
);
  import ssfq_pkg::*;

  logic        present_q, present_d;
  logic        second_q, second_d;
  logic [11:0] reading_q, reading_d;
  logic [3:0]  present_run_q, present_run_d;
  logic [3:0]  absent_run_q, absent_run_d;
  logic [3:0]  present_inc, absent_inc;

  assign present_inc = present_run_q + 4'd1;
  assign absent_inc  = absent_run_q + 4'd1;

  always_comb begin
    present_d     = present_q | item_i.test_pin;
    second_d      = second_q;
    reading_d     = reading_q;
    present_run_d = present_run_q;
    absent_run_d  = absent_run_q;
    if (frame_i.good) begin
      second_d  = frame_i.word[SECOND_BIT];
      reading_d = frame_i.word[11:0];
      if (frame_i.word[11:0] != NO_STRIP) begin
        absent_run_d = 4'd0;
        if (present_inc >= cfg_i.present_run_needed) begin
          present_run_d = 4'd0;
          present_d     = 1'b1;
        end else begin
          present_run_d = present_inc;
        end
      end else begin
        present_run_d = 4'd0;
        if (absent_inc >= cfg_i.absent_run_needed) begin
          absent_run_d = 4'd0;
          present_d    = 1'b0;
        end else begin
          absent_run_d = absent_inc;
        end
      end
    end
    // consumer clear is applied last in the tick
    if (item_i.clear_present) begin
      present_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q     <= 1'b0;
      second_q      <= 1'b0;
      reading_q     <= 12'h000;
      present_run_q <= 4'd0;
      absent_run_q  <= 4'd0;
    end else if (advance_i) begin
      present_q     <= present_d;
      second_q      <= second_d;
      reading_q     <= reading_d;
      present_run_q <= present_run_d;
      absent_run_q  <= absent_run_d;
    end
  end

  assign present_o = present_q;
  assign second_o  = second_q;
  assign reading_o = reading_q;

endmodule

/* tb/sv/tb_strip_sensor_frame_qualifier.sv */
// ----------------------------------------------------------------------------
// tb_strip_sensor_frame_qualifier
// Drives ticks (optional byte, test pin, consumer clear) into the frame
// qualifier, predicts the parser and run counters tick by tick, and checks
// every status transaction in order under several threshold settings and
// random idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_strip_sensor_frame_qualifier;
  import ssfq_pkg::*;

  typedef enum logic [1:0] {WAIT_HDR, WAIT_HI, WAIT_LO, WAIT_SUM} frame_step_e;

  typedef struct packed {
    logic        present;
    logic        second;
    logic [11:0] reading;
    logic        good;
    logic        bad;
  } strip_status_t;

  class strip_frame_scoreboard;
    ssfq_cfg_t     cfg;
    frame_step_e   step;
    logic [3:0]    timeout_left;
    logic [15:0]   frame_word;
    logic [3:0]    present_run;
    logic [3:0]    absent_run;
    logic          present_flag;
    logic          second_flag;
    logic [11:0]   held_reading;
    strip_status_t status_q[$];
    int unsigned   mismatches;

    function new();
      cfg          = '{4'd3, 4'd3, 4'd3};
      step         = WAIT_HDR;
      timeout_left = '0;
      frame_word   = '0;
      present_run  = '0;
      absent_run   = '0;
      present_flag = 1'b0;
      second_flag  = 1'b0;
      held_reading = '0;
      mismatches   = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [3:0] val);
      case (idx)
        CFG_PRESENT_RUN: cfg.present_run_needed = val;
        CFG_ABSENT_RUN:  cfg.absent_run_needed = val;
        CFG_TIMEOUT:     cfg.frame_timeout_ticks = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void note_tick(ssfq_item_t it);
      logic [7:0]    sum;
      strip_status_t st;
      st.good = 1'b0;
      st.bad  = 1'b0;
      if (it.test_pin) present_flag = 1'b1;
      if (it.byte_valid) begin
        case (step)
          WAIT_HDR: begin
            if (it.rx_byte == HDR_BYTE) begin
              step         = WAIT_HI;
              timeout_left = cfg.frame_timeout_ticks;
            end
          end
          WAIT_HI: begin
            frame_word = {8'h00, it.rx_byte};
            step       = WAIT_LO;
          end
          WAIT_LO: begin
            frame_word = {frame_word[7:0], it.rx_byte};
            step       = WAIT_SUM;
          end
          default: begin
            sum = HDR_BYTE + frame_word[15:8] + frame_word[7:0];
            if (it.rx_byte != sum) begin
              st.bad = 1'b1;
            end else begin
              st.good      = 1'b1;
              second_flag  = frame_word[SECOND_BIT];
              held_reading = frame_word[11:0];
              if (held_reading != NO_STRIP) begin
                absent_run  = '0;
                present_run = present_run + 4'd1;
                if (present_run >= cfg.present_run_needed) begin
                  present_run  = '0;
                  present_flag = 1'b1;
                end
              end else begin
                present_run = '0;
                absent_run  = absent_run + 4'd1;
                if (absent_run >= cfg.absent_run_needed) begin
                  absent_run   = '0;
                  present_flag = 1'b0;
                end
              end
            end
            step         = WAIT_HDR;
            timeout_left = '0;
          end
        endcase
      end else if (timeout_left != 0) begin
        timeout_left = timeout_left - 4'd1;
        if (timeout_left == 0) step = WAIT_HDR;
      end
      if (it.clear_present) present_flag = 1'b0;
      st.present = present_flag;
      st.second  = second_flag;
      st.reading = held_reading;
      status_q.push_back(st);
    endfunction

    function void check_field(string name, logic [11:0] exp_v, logic [11:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_status(logic present, logic second, logic [11:0] reading,
                               logic good, logic bad);
      strip_status_t want;
      if (status_q.size() == 0) begin
        $display("%0t: status transaction with nothing expected", $time);
        mismatches++;
        return;
      end
      want = status_q.pop_front();
      check_field("strip_present", 12'(want.present), 12'(present));
      check_field("second_strip", 12'(want.second), 12'(second));
      check_field("strip_reading", want.reading, reading);
      check_field("frame_good", 12'(want.good), 12'(good));
      check_field("frame_bad", 12'(want.bad), 12'(bad));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        byte_valid_i = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        test_pin_i = 1'b0;
  logic        clear_present_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        strip_present_o;
  logic        second_strip_o;
  logic [11:0] strip_reading_o;
  logic        frame_good_o;
  logic        frame_bad_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_PRESENT_RUN;
  logic [3:0]  cfg_data_i = 4'd0;

  strip_frame_scoreboard sb;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          flag_pct = 0;
  int          gap_pct = 0;
  int          cur_timeout = 3;
  int          ticks_sent = 0;

  // thresholds per random phase: present run, absent run, frame timeout
  logic [3:0] present_tbl [8] = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd15, 4'd1, 4'd3, 4'd5};
  logic [3:0] absent_tbl  [8] = '{4'd1, 4'd15, 4'd0, 4'd4, 4'd1, 4'd15, 4'd3, 4'd2};
  logic [3:0] timeout_tbl [8] = '{4'd1, 4'd15, 4'd0, 4'd6, 4'd9, 4'd2, 4'd3, 4'd15};

  strip_sensor_frame_qualifier u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .byte_valid_i,
    .rx_byte_i,
    .test_pin_i,
    .clear_present_i,
    .out_valid_o,
    .out_stall_i,
    .strip_present_o,
    .second_strip_o,
    .strip_reading_o,
    .frame_good_o,
    .frame_bad_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_status(strip_present_o, second_strip_o, strip_reading_o,
                      frame_good_o, frame_bad_o);
    end
  end

  function automatic ssfq_item_t tick_of(logic bv, logic [7:0] b, logic tp, logic clr);
    ssfq_item_t it;
    it.byte_valid    = bv;
    it.rx_byte       = b;
    it.test_pin      = tp;
    it.clear_present = clr;
    return it;
  endfunction

  function automatic ssfq_item_t mk_tick(logic bv, logic [7:0] b);
    return tick_of(bv, b, $urandom_range(99) < flag_pct, $urandom_range(99) < flag_pct);
  endfunction

  function automatic logic [15:0] strip_word(bit no_strip);
    logic [15:0] w;
    w = 16'($urandom);
    if (no_strip) w[11:0] = NO_STRIP;
    else if (w[11:0] == NO_STRIP) w[0] = ~w[0];
    return w;
  endfunction

  task automatic send_tick(ssfq_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    byte_valid_i    <= it.byte_valid;
    rx_byte_i       <= it.rx_byte;
    test_pin_i      <= it.test_pin;
    clear_present_i <= it.clear_present;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_tick(it);
    ticks_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_tick(mk_tick(1'b1, b));
  endtask

  // byte-less ticks inside a frame, kept below the timeout in total
  task automatic send_gaps(inout int budget);
    int n;
    if (budget > 0 && $urandom_range(99) < gap_pct) begin
      n = $urandom_range(budget, 1);
      budget -= n;
      repeat (n) send_tick(mk_tick(1'b0, 8'($urandom)));
    end
  endtask

  task automatic send_frame(logic [15:0] word, bit corrupt);
    logic [7:0] sum;
    int         budget;
    sum = HDR_BYTE + word[15:8] + word[7:0];
    if (corrupt) sum = sum ^ 8'($urandom_range(255, 1));
    budget = (cur_timeout == 0) ? 5 : cur_timeout - 1;
    send_byte(HDR_BYTE);
    send_gaps(budget);
    send_byte(word[15:8]);
    send_gaps(budget);
    send_byte(word[7:0]);
    send_gaps(budget);
    send_byte(sum);
  endtask

  // sender holds off until every status transaction is back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(logic [3:0] pres, logic [3:0] abs_n, logic [3:0] tmo);
    write_reg(CFG_PRESENT_RUN, pres);
    write_reg(CFG_ABSENT_RUN, abs_n);
    write_reg(CFG_TIMEOUT, tmo);
    cfg_valid_i <= 1'b0;
    cur_timeout = tmo;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 57; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 57; end
      default: begin idle_pct = 22; stall_pct = 22; end
    endcase
  endtask

  task automatic run_random(int n_ticks);
    int start;
    int roll;
    int run_len;
    bit no_strip;
    start = ticks_sent;
    while (ticks_sent - start < n_ticks) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        no_strip = 1'($urandom_range(1));
        run_len  = ($urandom_range(3) == 0) ? $urandom_range(18, 5) : $urandom_range(4, 1);
        repeat (run_len) send_frame(strip_word(no_strip), $urandom_range(9) == 0);
      end else if (roll < 70) begin
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
      end else if (roll < 80) begin
        repeat ($urandom_range(4, 1)) send_tick(mk_tick(1'b0, 8'($urandom)));
      end else if (roll < 90) begin
        // partial frame, then, unless the timeout is zero, enough quiet ticks to drop it
        send_byte(HDR_BYTE);
        repeat ($urandom_range(2, 0)) send_byte(8'($urandom));
        if (cur_timeout != 0) repeat (cur_timeout) send_tick(mk_tick(1'b0, 8'($urandom)));
      end else begin
        send_tick(mk_tick(1'($urandom), 8'($urandom)));
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("[strip_sensor_frame_qualifier] ERROR");
    $finish;
  end

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed ticks at reset thresholds
    send_tick(tick_of(1'b0, 8'h00, 1'b1, 1'b0));
    send_tick(tick_of(1'b0, 8'hFF, 1'b1, 1'b1));
    send_byte(8'h55);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(16'h1FFE, 1'b0);
    send_frame(16'hE000, 1'b1);
    send_byte(HDR_BYTE);
    repeat (3) send_tick(tick_of(1'b0, 8'h00, 1'b0, 1'b0));
    send_frame(16'h07FF, 1'b0);
    send_frame(16'h0000, 1'b0);
    send_tick(tick_of(1'b0, 8'h00, 1'b0, 1'b1));
    wait_idle();

    flag_pct = 4;
    gap_pct  = 20;
    for (int p = 0; p < 8; p++) begin
      program_regs(present_tbl[p], absent_tbl[p], timeout_tbl[p]);
      set_idling(p % 4);
      run_random(115);
      wait_idle();
    end

    if (sb.mismatches == 0) begin
      $display("[strip_sensor_frame_qualifier] OK");
    end else begin
      $display("[strip_sensor_frame_qualifier] ERROR");
    end
    $finish;
  end

endmodule
